[rtl/asched_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging priority scheduler package
// Shared types and constants for the scheduler and its arithmetic unit.
// ----------------------------------------------------------------------------
package asched_pkg;

  typedef enum logic [1:0] {
    OpSetPrio = 2'd0,
    OpReady   = 2'd1,
    OpRemove  = 2'd2,
    OpSched   = 2'd3
  } op_e;

  localparam logic signed [5:0] PrioMax   = 6'sd20;
  localparam logic signed [5:0] PrioMin   = -6'sd20;
  localparam logic signed [3:0] StepReset = -4'sd1;

  typedef struct packed {
    logic       take;
    logic [7:0] aged;
  } alu_res_t;

endpackage

[rtl/asched_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler compare and aging unit
// Compares one dynamic priority against the running best and computes its
// saturated aged value.
// ----------------------------------------------------------------------------
module asched_alu (
  input  logic signed [7:0]     cur_i,
  input  logic signed [7:0]     best_i,
  input  logic                  first_i,
  input  logic signed [3:0]     step_i,
  output asched_pkg::alu_res_t  res_o
);
  import asched_pkg::*;

  logic [8:0] sum;

  assign sum = {cur_i[7], cur_i} + {{5{step_i[3]}}, step_i};

  always_comb begin
    res_o.take = first_i || (cur_i < best_i);
    if (sum[8] != sum[7]) begin
      res_o.aged = sum[8] ? 8'h80 : 8'h7F;
    end else begin
      res_o.aged = sum[7:0];
    end
  end

endmodule

[rtl/aging_priority_task_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aging priority task scheduler
// Task table with static and dynamic priorities and an ordered ready list,
// served by a small sequencer around one shared compare and aging unit.
//
//   Channel  Handshake                 Payload
//   request  start / busy              opcode_i, task_index_i, priority_req_i
//   result   done_o (one-cycle strobe) chosen_valid_o, chosen_task_o,
//                                      chosen_prio_o
//   config   cfg_valid_i / cfg_ready_o cfg_data_i (aging step)
//
// Remove and make ready first compact the ready list when the task is already
// in it, and a make ready then appends the task at the end. Schedule makes a
// single pass over the ready list memory.
// Reset clears all priorities, the ready list and sets the aging step to -1;
// no clearing pass is needed. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module aging_priority_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        opcode_i,
  input  logic [3:0]        task_index_i,
  input  logic signed [5:0] priority_req_i,
  output logic              done_o,
  output logic              chosen_valid_o,
  output logic [3:0]        chosen_task_o,
  output logic signed [7:0] chosen_prio_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic signed [3:0] cfg_data_i
);
  import asched_pkg::*;

  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    StIdle, StExec, StDrop, StAppend, StScan, StFixRd, StFixWr
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [TW-1:0]     slot_q, slot_d;
  logic              slot_ok_q, slot_ok_d;
  logic signed [5:0] req_q, req_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic [CW-1:0]     wr_idx_q, wr_idx_d;
  logic              p1_q, p1_d, p2_q, p2_d;
  logic              first_q, first_d;
  logic [TW-1:0]     best_q, best_d;
  logic [7:0]        best_prio_q, best_prio_d;
  logic [TW-1:0]     t2_q, t2_d;
  logic              done_q, done_d;
  logic              cvalid_q, cvalid_d;
  logic [3:0]        ctask_q, ctask_d;
  logic [7:0]        cprio_q, cprio_d;
  logic signed [3:0] step_q;

  logic [TW-1:0] order_mem [MAX_TASKS];
  logic [5:0]    stat_mem  [MAX_TASKS];
  logic [7:0]    dyn_mem   [MAX_TASKS];
  logic [TW-1:0] order_rd_q;
  logic [5:0]    stat_rd_q;
  logic [7:0]    dyn_rd_q;
  logic          dyn_vld_q;
  logic [MAX_TASKS-1:0] prio_vld_q;
  logic [MAX_TASKS-1:0] in_ready_q;

  logic          order_we, order_re;
  logic [TW-1:0] order_waddr, order_raddr, order_wdata;
  logic          stat_we, stat_re;
  logic [TW-1:0] stat_waddr, stat_raddr;
  logic [5:0]    stat_wdata;
  logic          dyn_we, dyn_re;
  logic [TW-1:0] dyn_waddr, dyn_raddr;
  logic [7:0]    dyn_wdata;
  logic          vld_set;
  logic [TW-1:0] vld_addr;
  logic          rdy_set, rdy_clr;
  alu_res_t      alu_res;

  asched_alu u_alu (
    .cur_i   (dyn_rd_q),
    .best_i  (best_prio_q),
    .first_i (first_q),
    .step_i  (step_q),
    .res_o   (alu_res)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    slot_d      = slot_q;
    slot_ok_d   = slot_ok_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    first_d     = first_q;
    best_d      = best_q;
    best_prio_d = best_prio_q;
    t2_d        = t2_q;
    done_d      = 1'b0;
    cvalid_d    = cvalid_q;
    ctask_d     = ctask_q;
    cprio_d     = cprio_q;
    order_we    = 1'b0;
    order_re    = 1'b0;
    order_waddr = '0;
    order_raddr = '0;
    order_wdata = '0;
    stat_we     = 1'b0;
    stat_re     = 1'b0;
    stat_waddr  = '0;
    stat_raddr  = '0;
    stat_wdata  = '0;
    dyn_we      = 1'b0;
    dyn_re      = 1'b0;
    dyn_waddr   = '0;
    dyn_raddr   = '0;
    dyn_wdata   = '0;
    vld_set     = 1'b0;
    vld_addr    = slot_q;
    rdy_set     = 1'b0;
    rdy_clr     = 1'b0;

    case (state_q)
      StIdle: begin
        if (start) begin
          op_d      = op_e'(opcode_i);
          slot_d    = TW'(task_index_i);
          slot_ok_d = {28'd0, task_index_i} < 32'(MAX_TASKS);
          if (priority_req_i > PrioMax) begin
            req_d = PrioMax;
          end else if (priority_req_i < PrioMin) begin
            req_d = PrioMin;
          end else begin
            req_d = priority_req_i;
          end
          state_d = StExec;
        end
      end
      StExec: begin
        state_d  = StIdle;
        done_d   = 1'b1;
        cvalid_d = 1'b0;
        ctask_d  = '0;
        cprio_d  = '0;
        case (op_q)
          OpSetPrio: begin
            if (slot_ok_q) begin
              stat_we    = 1'b1;
              stat_waddr = slot_q;
              stat_wdata = req_q;
              dyn_we     = 1'b1;
              dyn_waddr  = slot_q;
              dyn_wdata  = {{2{req_q[5]}}, req_q};
              vld_set    = 1'b1;
            end
          end
          OpReady, OpRemove: begin
            if (slot_ok_q && in_ready_q[slot_q]) begin
              rd_idx_d = '0;
              wr_idx_d = '0;
              p1_d     = 1'b0;
              state_d  = StDrop;
              done_d   = 1'b0;
            end else if (slot_ok_q && op_q == OpReady) begin
              state_d = StAppend;
              done_d  = 1'b0;
            end
          end
          OpSched: begin
            if (cnt_q != '0) begin
              rd_idx_d = '0;
              p1_d     = 1'b0;
              p2_d     = 1'b0;
              first_d  = 1'b1;
              state_d  = StScan;
              done_d   = 1'b0;
            end
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end
      StDrop: begin
        if (rd_idx_q < cnt_q) begin
          order_re    = 1'b1;
          order_raddr = rd_idx_q[TW-1:0];
          rd_idx_d    = rd_idx_q + 1'b1;
          p1_d        = 1'b1;
        end else begin
          p1_d = 1'b0;
        end
        if (p1_q && order_rd_q != slot_q) begin
          order_we    = 1'b1;
          order_waddr = wr_idx_q[TW-1:0];
          order_wdata = order_rd_q;
          wr_idx_d    = wr_idx_q + 1'b1;
        end
        if (rd_idx_q == cnt_q && !p1_q) begin
          cnt_d   = wr_idx_q;
          rdy_clr = 1'b1;
          if (op_q == OpReady) begin
            state_d = StAppend;
          end else begin
            state_d = StIdle;
            done_d  = 1'b1;
          end
        end
      end
      StAppend: begin
        if (cnt_q < CW'(MAX_TASKS)) begin
          order_we    = 1'b1;
          order_waddr = cnt_q[TW-1:0];
          order_wdata = slot_q;
          cnt_d       = cnt_q + 1'b1;
          rdy_set     = 1'b1;
        end
        state_d = StIdle;
        done_d  = 1'b1;
      end
      StScan: begin
        if (rd_idx_q < cnt_q) begin
          order_re    = 1'b1;
          order_raddr = rd_idx_q[TW-1:0];
          rd_idx_d    = rd_idx_q + 1'b1;
          p1_d        = 1'b1;
        end else begin
          p1_d = 1'b0;
        end
        p2_d = p1_q;
        if (p1_q) begin
          dyn_re    = 1'b1;
          dyn_raddr = order_rd_q;
          t2_d      = order_rd_q;
        end
        if (p2_q) begin
          dyn_we    = 1'b1;
          dyn_waddr = t2_q;
          dyn_wdata = alu_res.aged;
          if (!dyn_vld_q) begin
            stat_we    = 1'b1;
            stat_waddr = t2_q;
            stat_wdata = '0;
            vld_set    = 1'b1;
            vld_addr   = t2_q;
          end
          if (alu_res.take) begin
            best_d      = t2_q;
            best_prio_d = dyn_rd_q;
          end
          first_d = 1'b0;
        end
        if (rd_idx_q == cnt_q && !p1_q && !p2_q) begin
          state_d = StFixRd;
        end
      end
      StFixRd: begin
        stat_re    = 1'b1;
        stat_raddr = best_q;
        state_d    = StFixWr;
      end
      StFixWr: begin
        dyn_we    = 1'b1;
        dyn_waddr = best_q;
        dyn_wdata = {{2{stat_rd_q[5]}}, stat_rd_q};
        done_d    = 1'b1;
        cvalid_d  = 1'b1;
        ctask_d   = 4'(best_q);
        cprio_d   = best_prio_q;
        state_d   = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      op_q        <= OpSetPrio;
      slot_q      <= '0;
      slot_ok_q   <= 1'b0;
      req_q       <= '0;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      first_q     <= 1'b0;
      best_q      <= '0;
      best_prio_q <= '0;
      t2_q        <= '0;
      done_q      <= 1'b0;
      cvalid_q    <= 1'b0;
      ctask_q     <= '0;
      cprio_q     <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      slot_q      <= slot_d;
      slot_ok_q   <= slot_ok_d;
      req_q       <= req_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      first_q     <= first_d;
      best_q      <= best_d;
      best_prio_q <= best_prio_d;
      t2_q        <= t2_d;
      done_q      <= done_d;
      cvalid_q    <= cvalid_d;
      ctask_q     <= ctask_d;
      cprio_q     <= cprio_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= StepReset;
      prio_vld_q <= '0;
      in_ready_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        step_q <= cfg_data_i;
      end
      if (vld_set) begin
        prio_vld_q[vld_addr] <= 1'b1;
      end
      if (rdy_set) begin
        in_ready_q[slot_q] <= 1'b1;
      end else if (rdy_clr) begin
        in_ready_q[slot_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (order_we) begin
      order_mem[order_waddr] <= order_wdata;
    end
    if (order_re) begin
      order_rd_q <= order_mem[order_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_we) begin
      stat_mem[stat_waddr] <= stat_wdata;
    end
    if (stat_re) begin
      stat_rd_q <= stat_mem[stat_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dyn_we) begin
      dyn_mem[dyn_waddr] <= dyn_wdata;
    end
    if (dyn_re) begin
      dyn_rd_q  <= prio_vld_q[dyn_raddr] ? dyn_mem[dyn_raddr] : 8'h00;
      dyn_vld_q <= prio_vld_q[dyn_raddr];
    end
  end

  assign busy           = (state_q != StIdle);
  assign done_o         = done_q;
  assign chosen_valid_o = cvalid_q;
  assign chosen_task_o  = ctask_q;
  assign chosen_prio_o  = cprio_q;
  assign cfg_ready_o    = 1'b1;

endmodule
